### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They rely on clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// Types and constants shared by the single-wire sensor receiver modules.
// ----------------------------------------------------------------------------
package swsr_pkg;

  // Default sizing of the block.
  localparam int MAX_BYTES_DEF  = 8;
  localparam int COUNT_BITS_DEF = 20;

  // Configuration port geometry.
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_CNT_W = 4;
  localparam int NUM_DELAYS = 6;

  // Register indexes; the delay registers occupy the lowest indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 3'd6;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] DELAY_RST [NUM_DELAYS] =
    '{20'd18000, 20'd30, 20'd100, 20'd40, 20'd80, 20'd30};
  localparam logic [BYTE_CNT_W-1:0] BYTE_COUNT_RST = 4'd5;

  // Completion status of a read.
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_NO_RESP = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  // One result beat.
  typedef struct packed {
    logic       drive_low;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    status_t    status;
    logic       busy_res;
  } result_t;

endpackage

### hdl/swsr_cfg.sv
// ----------------------------------------------------------------------------
// swsr_cfg
// Configuration registers. Delays are clamped to the tick counter range and
// the byte count to 1..MAX_BYTES as they are written.
// ----------------------------------------------------------------------------
module swsr_cfg import swsr_pkg::*; #(
  parameter int MAX_BYTES  = MAX_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int BW        = $clog2(MAX_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic [COUNT_BITS-1:0] delay_val [NUM_DELAYS],
  output logic                  delay_zero [NUM_DELAYS],
  output logic [BW-1:0]         bytes_wanted
);

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [COUNT_BITS-1:0] delay_r [NUM_DELAYS];
  logic                  zero_r  [NUM_DELAYS];
  logic [BW-1:0]         bytes_r;

  // Saturate a written delay at the largest count the counter can hold.
  function automatic logic [COUNT_BITS-1:0] clamp_delay(input logic [CFG_W-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > CNT_MAX) begin
      return CNT_MAX[COUNT_BITS-1:0];
    end
    return wide[COUNT_BITS-1:0];
  endfunction

  // A byte count of zero reads one byte; large counts stop at the maximum.
  function automatic logic [BW-1:0] clamp_bytes(input logic [BYTE_CNT_W-1:0] n);
    if (n == '0) begin
      return BW'(1);
    end
    if (32'(n) > MAX_BYTES) begin
      return BW'(MAX_BYTES);
    end
    return BW'(n);
  endfunction

  // Register file with write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DELAYS; i++) begin
        delay_r[i] <= clamp_delay(DELAY_RST[i]);
        zero_r[i]  <= (DELAY_RST[i] == '0);
      end
      bytes_r <= clamp_bytes(BYTE_COUNT_RST);
    end else if (cfg_we) begin
      if (cfg_idx <= REG_SAMPLE_DELAY) begin
        delay_r[cfg_idx] <= clamp_delay(cfg_wdata);
        zero_r[cfg_idx]  <= (cfg_wdata == '0);
      end else if (cfg_idx == REG_BYTE_COUNT) begin
        bytes_r <= clamp_bytes(cfg_wdata[BYTE_CNT_W-1:0]);
      end
    end
  end

  assign delay_val    = delay_r;
  assign delay_zero   = zero_r;
  assign bytes_wanted = bytes_r;

endmodule

### hdl/swsr_fsm.sv
// ----------------------------------------------------------------------------
// swsr_fsm
// Read sequencer. Handles one tick per enabled cycle, including phases that
// pass straight on within the same tick when their delay is zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swsr_fsm import swsr_pkg::*; #(
  parameter int MAX_BYTES  = MAX_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int BW        = $clog2(MAX_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  action,
  input  logic                  line,
  input  logic [COUNT_BITS-1:0] delay_val [NUM_DELAYS],
  input  logic                  delay_zero [NUM_DELAYS],
  input  logic [BW-1:0]         bytes_wanted,
  output result_t               res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LOW, PH_RELEASE, PH_WAIT_LOW, PH_RESP_LOW,
    PH_RESP_HIGH, PH_BIT_RISE, PH_BIT_DELAY, PH_BIT_FALL
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [2:0]            bidx_r, bidx_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [BW-1:0]         bdone_r, bdone_nxt;

  phase_t                ph0;
  logic [COUNT_BITS-1:0] cnt0, cnt_inc, dsel;
  logic [2:0]            bidx0;
  logic [7:0]            shift0;
  logic [BW-1:0]         bdone0;
  logic                  start_exp;

  // A start action in idle opens a fresh read.
  always_comb begin
    ph0    = phase_r;
    cnt0   = cnt_r;
    bidx0  = bidx_r;
    shift0 = shift_r;
    bdone0 = bdone_r;
    if (phase_r == PH_IDLE && action) begin
      ph0    = PH_LOW;
      cnt0   = '0;
      bidx0  = '0;
      shift0 = '0;
      bdone0 = '0;
    end
  end

  // One delay compare for the phase the tick starts in.
  always_comb begin
    case (ph0)
      PH_LOW:       dsel = delay_val[REG_START_LOW];
      PH_RELEASE:   dsel = delay_val[REG_RELEASE_WAIT];
      PH_WAIT_LOW:  dsel = delay_val[REG_RESP_TIMEOUT];
      PH_RESP_LOW:  dsel = delay_val[REG_RESP_LOW];
      PH_RESP_HIGH: dsel = delay_val[REG_RESP_HIGH];
      PH_BIT_DELAY: dsel = delay_val[REG_SAMPLE_DELAY];
      default:      dsel = delay_val[REG_START_LOW];
    endcase
  end

  assign start_exp = (cnt0 >= dsel);
  assign cnt_inc   = cnt0 + COUNT_BITS'(1);

  // Phase chain in order. A phase entered within this tick starts at count
  // zero, so its delay has expired exactly when the delay is zero.
  always_comb begin
    logic       first;
    logic       go;
    logic [7:0] sh_new;
    phase_nxt = ph0;
    cnt_nxt   = cnt0;
    bidx_nxt  = bidx0;
    shift_nxt = shift0;
    bdone_nxt = bdone0;
    first     = 1'b1;
    go        = 1'b1;
    sh_new    = '0;
    res       = '0;

    if (go && phase_nxt == PH_LOW) begin
      if (first ? start_exp : delay_zero[REG_START_LOW]) begin
        phase_nxt = PH_RELEASE;
        cnt_nxt   = '0;
        first     = 1'b0;
      end else begin
        res.drive_low = 1'b1;
        cnt_nxt       = first ? cnt_inc : COUNT_BITS'(1);
        go            = 1'b0;
      end
    end

    if (go && phase_nxt == PH_RELEASE) begin
      if (first ? start_exp : delay_zero[REG_RELEASE_WAIT]) begin
        phase_nxt = PH_WAIT_LOW;
        cnt_nxt   = '0;
        first     = 1'b0;
      end else begin
        cnt_nxt = first ? cnt_inc : COUNT_BITS'(1);
        go      = 1'b0;
      end
    end

    if (go && phase_nxt == PH_WAIT_LOW) begin
      if (!line) begin
        phase_nxt = PH_RESP_LOW;
        cnt_nxt   = '0;
        first     = 1'b0;
      end else if (first ? start_exp : delay_zero[REG_RESP_TIMEOUT]) begin
        res.status = ST_TIMEOUT;
        phase_nxt  = PH_IDLE;
        cnt_nxt    = '0;
        go         = 1'b0;
      end else begin
        cnt_nxt = first ? cnt_inc : COUNT_BITS'(1);
        go      = 1'b0;
      end
    end

    if (go && phase_nxt == PH_RESP_LOW) begin
      if (first ? start_exp : delay_zero[REG_RESP_LOW]) begin
        cnt_nxt = '0;
        if (line) begin
          phase_nxt = PH_RESP_HIGH;
          first     = 1'b0;
        end else begin
          res.status = ST_NO_RESP;
          phase_nxt  = PH_IDLE;
          go         = 1'b0;
        end
      end else begin
        cnt_nxt = first ? cnt_inc : COUNT_BITS'(1);
        go      = 1'b0;
      end
    end

    if (go && phase_nxt == PH_RESP_HIGH) begin
      if (first ? start_exp : delay_zero[REG_RESP_HIGH]) begin
        phase_nxt = PH_BIT_RISE;
        cnt_nxt   = '0;
        first     = 1'b0;
      end else begin
        cnt_nxt = first ? cnt_inc : COUNT_BITS'(1);
        go      = 1'b0;
      end
    end

    // Falling edge that ends the previous bit.
    if (go && phase_nxt == PH_BIT_FALL) begin
      if (!line) begin
        phase_nxt = PH_BIT_RISE;
      end else begin
        go = 1'b0;
      end
    end

    if (go && phase_nxt == PH_BIT_RISE) begin
      if (line) begin
        phase_nxt = PH_BIT_DELAY;
        cnt_nxt   = '0;
        first     = 1'b0;
      end else begin
        go = 1'b0;
      end
    end

    // Bit sample; every eighth bit completes a byte.
    if (go && phase_nxt == PH_BIT_DELAY) begin
      if (first ? start_exp : delay_zero[REG_SAMPLE_DELAY]) begin
        cnt_nxt   = '0;
        sh_new    = {shift_nxt[6:0], line};
        phase_nxt = PH_BIT_FALL;
        if (bidx_nxt == 3'd7) begin
          bidx_nxt       = '0;
          bdone_nxt      = bdone_nxt + BW'(1);
          res.byte_valid = 1'b1;
          res.data_byte  = sh_new;
          shift_nxt      = '0;
          if (bdone_nxt >= bytes_wanted) begin
            res.last_byte = 1'b1;
            res.status    = ST_DONE;
            phase_nxt     = PH_IDLE;
            go            = 1'b0;
          end
        end else begin
          bidx_nxt  = bidx_nxt + 3'd1;
          shift_nxt = sh_new;
        end
      end else begin
        cnt_nxt = first ? cnt_inc : COUNT_BITS'(1);
        go      = 1'b0;
      end
    end

    // The line is high after a sample from a rising edge, so this only moves
    // on when the sample itself started the tick with a low line.
    if (go && phase_nxt == PH_BIT_FALL) begin
      if (!line) begin
        phase_nxt = PH_BIT_RISE;
      end
    end

    res.busy_res = (phase_nxt != PH_IDLE);
  end

  // State registers advance once per handled tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      bdone_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      bdone_r <= bdone_nxt;
    end
  end

  `ASSERT_CLK(a_last_done, res.last_byte |-> (res.byte_valid && (res.status == ST_DONE)), "last byte without done status")
  `ASSERT_NEVER(a_drive_idle, res.drive_low && !res.busy_res, "line driven while not busy")
  `ASSERT_CLK(a_end_idle, (step_en && (res.status != ST_NONE)) |=> (phase_r == PH_IDLE), "read ended but sequencer not idle")

endmodule

### hdl/single_wire_sensor_receiver_core.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_receiver_core
// Host side of a single-wire temperature and humidity sensor read.
// ----------------------------------------------------------------------------
// Each input beat is one microsecond tick carrying the sampled line level and
// a start flag, and each produces exactly one result beat. The block takes a
// beat every clock cycle unless the result side stalls. A beat is held in the
// input register from the edge that accepts it, and the sequencer's result for it
// is then loaded into the result register once that register is free or being
// taken; the sequencer handles one tick per cycle while the result side does not
// stall. Both registers hold under back-pressure on the result side.
`include "assert_macros.svh"

module single_wire_sensor_receiver_core import swsr_pkg::*; #(
  parameter int MAX_BYTES  = MAX_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input beats
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,  // [0] line_level, [7:1] zero
  input  logic                 in_tuser,  // [0] action
  // Result beats
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata, // [0] drive_low, [1] byte_valid,
                                          // [9:2] data_byte, [11:10] status,
                                          // [12] busy_res, [15:13] zero
  output logic                 out_tlast, // last_byte
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int BW = $clog2(MAX_BYTES + 1);

  logic                  in_vld_r;
  logic                  in_action_r;
  logic                  in_line_r;
  logic                  out_vld_r;
  result_t               out_res_r;
  result_t               res;
  logic                  adv;
  logic [COUNT_BITS-1:0] delay_val [NUM_DELAYS];
  logic                  delay_zero [NUM_DELAYS];
  logic [BW-1:0]         bytes_wanted;

  swsr_cfg #(
    .MAX_BYTES  (MAX_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .delay_val    (delay_val),
    .delay_zero   (delay_zero),
    .bytes_wanted (bytes_wanted)
  );

  // The pipeline moves whenever the result register is free or being taken.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  swsr_fsm #(
    .MAX_BYTES  (MAX_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (in_vld_r && adv),
    .action       (in_action_r),
    .line         (in_line_r),
    .delay_val    (delay_val),
    .delay_zero   (delay_zero),
    .bytes_wanted (bytes_wanted),
    .res          (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= in_tuser;
      in_line_r   <= in_tdata[0];
    end
    if (in_vld_r && adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_res_r.last_byte;
  assign out_tdata  = {3'b000, out_res_r.busy_res, out_res_r.status,
                       out_res_r.data_byte, out_res_r.byte_valid, out_res_r.drive_low};

  `ASSERT_CLK(a_rdy_empty, !out_vld_r |-> in_tready, "not ready with empty result register")
  `ASSERT_CLK(a_load, (in_vld_r && adv) |=> out_vld_r, "handled beat did not reach the result register")

endmodule

### bench/tb_single_wire_sensor_receiver_core.sv
// ----------------------------------------------------------------------------
// tb_single_wire_sensor_receiver_core
// Self-checking bench for the host side of a single-wire sensor read.
// ----------------------------------------------------------------------------
// Ticks are sent as input beats, each carrying the sampled line level and a
// start flag. A sensor model picks each line level from the predicted state
// of the sequencer, so most reads get all the way to the data bytes, and some
// reads carry line noise, a stuck-high line or a deliberate fault. Every
// accepted tick yields one predicted result beat, and the result stream is
// compared field by field against those predictions. Both stream sides idle
// and stall at random, and the timing registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_single_wire_sensor_receiver_core;
  import swsr_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [CFG_W-1:0] DELAY_MAX = '1;
  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Sequencer phases as seen by the predictor.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_HOLD_LOW,
    SEQ_RELEASE,
    SEQ_WAIT_LOW,
    SEQ_RESP_LOW,
    SEQ_RESP_HIGH,
    SEQ_BIT_RISE,
    SEQ_BIT_DELAY,
    SEQ_BIT_FALL
  } seq_phase_t;

  // How the sensor model drives the line during a read.
  typedef enum logic [1:0] {
    LINE_SENSOR,
    LINE_NOISE,
    LINE_HIGH
  } line_mode_t;

  // Fault the sensor model injects into a well-formed read.
  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_TIMEOUT,
    FAULT_NO_RESP
  } fault_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;  // [0] line_level, [7:1] zero
  logic                 in_tuser   = 1'b0; // [0] action
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;  // [0] drive_low, [1] byte_valid,
                                    // [9:2] data_byte, [11:10] status,
                                    // [12] busy_res, [15:13] zero
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // Predicted sequencer state and register copy, at their reset values.
  seq_phase_t      seq_phase  = SEQ_IDLE;
  logic [CFG_W-1:0] seq_count = '0;
  logic [2:0]      bit_pos    = '0;
  logic [7:0]      shift_reg  = '0;
  logic [3:0]      byte_tally = '0;
  logic [CFG_W-1:0] delay_cfg [NUM_DELAYS] = '{20'd18000, 20'd30, 20'd100,
                                               20'd40, 20'd80, 20'd30};
  logic [BYTE_CNT_W-1:0] count_cfg = 4'd5;

  result_t expected_results [$];

  // Sensor model and pacing controls.
  line_mode_t cur_mode  = LINE_SENSOR;
  fault_t     cur_fault = FAULT_NONE;
  bit         calm      = 1'b0;

  // Run statistics.
  int ticks_sent    = 0;
  int reads_started = 0;
  int beats_checked = 0;
  int bytes_seen    = 0;
  int reads_done    = 0;
  int reads_timeout = 0;
  int reads_no_resp = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int stall_left    = 0;

  result_t seen_beat;
  result_t due_beat;

  single_wire_sensor_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advances the predicted sequencer by one tick and returns its result beat.
  // Delays of zero fall through to the next phase within the same tick.
  function automatic result_t step_sequencer(input logic act, input logic lvl);
    result_t r;
    logic again;
    logic [3:0] wanted;
    r = '0;
    wanted = (count_cfg == 4'd0) ? 4'd1 :
             (count_cfg > MAX_BYTES_DEF) ? 4'(MAX_BYTES_DEF) : count_cfg;
    if (seq_phase == SEQ_IDLE && act) begin
      seq_phase  = SEQ_HOLD_LOW;
      seq_count  = '0;
      bit_pos    = '0;
      shift_reg  = '0;
      byte_tally = '0;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (seq_phase)
        SEQ_HOLD_LOW: begin
          if (seq_count >= delay_cfg[REG_START_LOW]) begin
            seq_phase = SEQ_RELEASE;
            seq_count = '0;
            again = 1'b1;
          end else begin
            r.drive_low = 1'b1;
            seq_count++;
          end
        end
        SEQ_RELEASE: begin
          if (seq_count >= delay_cfg[REG_RELEASE_WAIT]) begin
            seq_phase = SEQ_WAIT_LOW;
            seq_count = '0;
            again = 1'b1;
          end else begin
            seq_count++;
          end
        end
        SEQ_WAIT_LOW: begin
          if (!lvl) begin
            seq_phase = SEQ_RESP_LOW;
            seq_count = '0;
            again = 1'b1;
          end else if (seq_count >= delay_cfg[REG_RESP_TIMEOUT]) begin
            r.status  = ST_TIMEOUT;
            seq_phase = SEQ_IDLE;
            seq_count = '0;
          end else begin
            seq_count++;
          end
        end
        SEQ_RESP_LOW: begin
          if (seq_count >= delay_cfg[REG_RESP_LOW]) begin
            seq_count = '0;
            if (lvl) begin
              seq_phase = SEQ_RESP_HIGH;
              again = 1'b1;
            end else begin
              r.status  = ST_NO_RESP;
              seq_phase = SEQ_IDLE;
            end
          end else begin
            seq_count++;
          end
        end
        SEQ_RESP_HIGH: begin
          if (seq_count >= delay_cfg[REG_RESP_HIGH]) begin
            seq_phase = SEQ_BIT_RISE;
            seq_count = '0;
            again = 1'b1;
          end else begin
            seq_count++;
          end
        end
        SEQ_BIT_RISE: begin
          if (lvl) begin
            seq_phase = SEQ_BIT_DELAY;
            seq_count = '0;
            again = 1'b1;
          end
        end
        SEQ_BIT_DELAY: begin
          if (seq_count >= delay_cfg[REG_SAMPLE_DELAY]) begin
            seq_count = '0;
            shift_reg = {shift_reg[6:0], lvl};
            seq_phase = SEQ_BIT_FALL;
            if (bit_pos == 3'd7) begin
              // Eighth bit: hand the byte out and maybe finish the read.
              bit_pos = '0;
              byte_tally++;
              r.byte_valid = 1'b1;
              r.data_byte  = shift_reg;
              shift_reg    = '0;
              if (byte_tally >= wanted) begin
                r.last_byte = 1'b1;
                r.status    = ST_DONE;
                seq_phase   = SEQ_IDLE;
              end
            end else begin
              bit_pos++;
            end
            again = (seq_phase != SEQ_IDLE);
          end else begin
            seq_count++;
          end
        end
        SEQ_BIT_FALL: begin
          if (!lvl) begin
            seq_phase = SEQ_BIT_RISE;
            again = 1'b1;
          end
        end
        default: seq_phase = SEQ_IDLE;
      endcase
    end
    r.busy_res = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  // Sensor model: picks the line level for the next tick from the predicted
  // state, so that well-formed reads reach the data bits.
  function automatic logic pick_level();
    if (cur_mode == LINE_HIGH) return 1'b1;
    if (cur_mode == LINE_NOISE) return 1'($urandom_range(0, 1));
    case (seq_phase)
      SEQ_WAIT_LOW: begin
        if (cur_fault == FAULT_TIMEOUT) return 1'b1;
        if (seq_count >= delay_cfg[REG_RESP_TIMEOUT]) return 1'b0;
        return ($urandom_range(0, 2) != 0);
      end
      SEQ_RESP_LOW: begin
        if (seq_count >= delay_cfg[REG_RESP_LOW]) return (cur_fault != FAULT_NO_RESP);
        return 1'b0;
      end
      SEQ_RESP_HIGH: begin
        if (seq_count >= delay_cfg[REG_RESP_HIGH]) return ($urandom_range(0, 3) == 0);
        return 1'b1;
      end
      SEQ_BIT_DELAY: begin
        if (seq_count >= delay_cfg[REG_SAMPLE_DELAY]) return 1'($urandom_range(0, 1));
        return 1'b1;
      end
      default: begin
        // Idle, hold and release may fall through to the wait for the low.
        if (cur_fault == FAULT_TIMEOUT) return 1'b1;
        return 1'($urandom_range(0, 1));
      end
    endcase
  endfunction

  // Idle length for either stream side: mostly none or short, a few long.
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one tick beat and records its predicted result.
  task automatic send_tick(input logic act, input logic lvl);
    int pause;
    pause = pick_pause();
    if (pause > 0) begin
      in_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, lvl};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(step_sequencer(act, lvl));
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the write takes effect at the following edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_BYTE_COUNT) count_cfg = val[BYTE_CNT_W-1:0];
    else if (idx <= REG_SAMPLE_DELAY) delay_cfg[idx] = val;
  endtask

  // Rewrites every register once the block is idle. Unused upper bits of the
  // byte count carry junk, which the block must drop.
  task automatic apply_settings(input logic [CFG_W-1:0] hold, rel, tmo, rlow, rhigh, smp,
                                input logic [BYTE_CNT_W-1:0] nbytes);
    logic [15:0] junk;
    junk = 16'($urandom);
    settle();
    write_reg(REG_START_LOW, hold);
    write_reg(REG_RELEASE_WAIT, rel);
    write_reg(REG_RESP_TIMEOUT, tmo);
    write_reg(REG_RESP_LOW, rlow);
    write_reg(REG_RESP_HIGH, rhigh);
    write_reg(REG_SAMPLE_DELAY, smp);
    write_reg(REG_BYTE_COUNT, {junk, nbytes});
    cfg_we <= 1'b0;
  endtask

  // Ticks with no start request and a random line.
  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // One whole read, from the start request until the block is idle again.
  // Stray start requests while busy must be ignored.
  task automatic run_read(input line_mode_t m, input fault_t f);
    cur_mode  = m;
    cur_fault = f;
    reads_started++;
    send_tick(1'b1, pick_level());
    while (seq_phase != SEQ_IDLE) send_tick($urandom_range(0, 19) == 0, pick_level());
  endtask

  // A read with the release and response-low times left by reset. Only the
  // hold time is shortened, and the sensor never answers high, so the read
  // ends early with the no-response status.
  task automatic test_reset_defaults();
    write_reg(REG_START_LOW, 20'd2);
    cfg_we <= 1'b0;
    idle_ticks(3);
    run_read(LINE_SENSOR, FAULT_NO_RESP);
  endtask

  // Delays at zero (the first read keeps a response-low time of one), so phases pass straight through within one tick.
  task automatic test_zero_delays();
    apply_settings(0, 0, 0, 1, 0, 0, 1);
    run_read(LINE_SENSOR, FAULT_NONE);
    apply_settings(0, 0, 0, 0, 0, 0, 2);
    run_read(LINE_SENSOR, FAULT_NONE);
    run_read(LINE_HIGH, FAULT_NONE);
  endtask

  // Each way a read can end: timeout, no response high, completion.
  task automatic test_status_codes();
    apply_settings(3, 2, 5, 2, 2, 1, 2);
    run_read(LINE_SENSOR, FAULT_TIMEOUT);
    run_read(LINE_SENSOR, FAULT_NO_RESP);
    run_read(LINE_SENSOR, FAULT_NONE);
  endtask

  // Byte counts of zero and above the maximum are clamped.
  task automatic test_byte_count_limits();
    apply_settings(1, 1, 4, 2, 1, 1, 0);
    run_read(LINE_SENSOR, FAULT_NONE);
    apply_settings(0, 1, 3, 1, 0, 1, 15);
    run_read(LINE_SENSOR, FAULT_NONE);
  endtask

  // Largest delay values, used where a read can still end quickly.
  task automatic test_extreme_delays();
    apply_settings(DELAY_MAX, DELAY_MAX, 0, DELAY_MAX, DELAY_MAX, DELAY_MAX, 8);
    apply_settings(0, 0, 0, DELAY_MAX, DELAY_MAX, DELAY_MAX, 15);
    @(posedge clk);
    write_reg(REG_UNUSED, 20'($urandom));
    cfg_we <= 1'b0;
    run_read(LINE_HIGH, FAULT_NONE);
    run_read(LINE_HIGH, FAULT_NONE);
    apply_settings(1, 0, DELAY_MAX, 1, 1, 0, 1);
    run_read(LINE_SENSOR, FAULT_NONE);
  endtask

  // Random settings and reads, mostly well formed, with noise and faults,
  // until at least 450 ticks have been sent over the whole run.
  task automatic test_random_reads();
    int r;
    line_mode_t m;
    fault_t f;
    logic [CFG_W-1:0] tmo;
    do begin
      calm = ($urandom_range(0, 3) == 0);
      tmo = CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(21, 120) :
                                                   $urandom_range(0, 20));
      apply_settings(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)), tmo,
                     CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)),
                     CFG_W'($urandom_range(0, 5)),
                     BYTE_CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
                                                                $urandom_range(1, 3)));
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        m = (r < 80) ? LINE_SENSOR : (r < 95) ? LINE_NOISE : LINE_HIGH;
        r = $urandom_range(0, 99);
        f = (r < 10) ? FAULT_TIMEOUT : (r < 20) ? FAULT_NO_RESP : FAULT_NONE;
        idle_ticks($urandom_range(0, 3));
        run_read(m, f);
      end
    end while (ticks_sent < 450);
    calm = 1'b0;
  endtask

  // Result side: random back-pressure and a check of every accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      seen_beat.drive_low  = out_tdata[0];
      seen_beat.byte_valid = out_tdata[1];
      seen_beat.data_byte  = out_tdata[9:2];
      seen_beat.last_byte  = out_tlast;
      seen_beat.status     = status_t'(out_tdata[11:10]);
      seen_beat.busy_res   = out_tdata[12];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d arrived with no prediction waiting", beats_checked);
      end else begin
        due_beat = expected_results.pop_front();
        if (due_beat.byte_valid) bytes_seen++;
        case (due_beat.status)
          ST_TIMEOUT: reads_timeout++;
          ST_NO_RESP: reads_no_resp++;
          ST_DONE:    reads_done++;
          default: ;
        endcase
        if (seen_beat !== due_beat) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"beat %0d mismatch: drive/valid/byte/last/status/busy ",
                      "expected %0b/%0b/%02h/%0b/%0d/%0b, got %0b/%0b/%02h/%0b/%0d/%0b"},
                     beats_checked,
                     due_beat.drive_low, due_beat.byte_valid, due_beat.data_byte,
                     due_beat.last_byte, due_beat.status, due_beat.busy_res,
                     seen_beat.drive_low, seen_beat.byte_valid, seen_beat.data_byte,
                     seen_beat.last_byte, seen_beat.status, seen_beat.busy_res);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = pick_pause();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_delays();
    test_status_codes();
    test_byte_count_limits();
    test_extreme_delays();
    test_random_reads();
    settle();
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats from %0d ticks over %0d reads, %0d data bytes.",
             beats_checked, ticks_sent, reads_started, bytes_seen);
    $display("Reads ended: %0d complete, %0d timed out, %0d without response; %0d mismatches.",
             reads_done, reads_timeout, reads_no_resp, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
